/* hdl/xcr_pkg.sv */
// Shared types and constants of the XMODEM checksum receiver.
`default_nettype none
package xcr_pkg;

    localparam int DATA_BYTES  = 128;
    localparam int FRAME_BYTES = 132;
    localparam int HEAD_BYTES  = 3;

    localparam int INDEX_W = 7;

    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;
    localparam logic [7:0] CODE_EOT = 8'h04;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  LIMIT_RESET   = 8'd10;

    // first data byte and sum byte positions within a frame
    localparam logic [7:0] DATA_FIRST = 8'(HEAD_BYTES);
    localparam logic [7:0] SUM_POS    = 8'(FRAME_BYTES - 1);

    typedef enum logic [0:0] {
        REG_FRAME_TIMEOUT = 1'b0,
        REG_REQUEST_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_DATA = 3'd1,
        EV_ACK  = 3'd2,
        EV_NAK  = 3'd3,
        EV_REQ  = 3'd4,
        EV_DONE = 3'd5,
        EV_FAIL = 3'd6
    } event_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic               data_valid;
        logic [INDEX_W-1:0] data_index;
        logic [7:0]         data_byte;
        logic               tx_valid;
        logic [7:0]         tx_byte;
        event_t             event_res;
    } res_t;

endpackage
`default_nettype wire

/* hdl/xcr_input_stage.sv */
// Input register of the receiver pipeline.
`default_nettype none
module xcr_input_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire xcr_pkg::item_t in_item,
    input  wire logic          advance,
    output logic               item_valid,
    output xcr_pkg::item_t     item
);
    import xcr_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/xcr_frame_fsm.sv */
// Transfer state machine: phase, frame counters, checksum and config registers.
`default_nettype none
module xcr_frame_fsm (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic           cfg_wr_index,
    input  wire logic [15:0]    cfg_wr_data,
    input  wire logic           step,
    input  wire xcr_pkg::item_t item,
    output xcr_pkg::res_t       res
);
    import xcr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  retry_count_reg, retry_count_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [15:0] frame_timeout_reg;
    logic [7:0]  request_limit_reg;

    logic        active;
    logic [15:0] tick_inc;
    logic [7:0]  retry_inc;
    logic [7:0]  data_offset;

    assign active      = (phase_reg == PH_WAIT) || (phase_reg == PH_RECV);
    assign tick_inc    = (tick_count_reg == 16'hFFFF) ? tick_count_reg : tick_count_reg + 16'd1;
    assign retry_inc   = (retry_count_reg == 8'hFF) ? retry_count_reg : retry_count_reg + 8'd1;
    assign data_offset = byte_count_reg - DATA_FIRST;

    always_comb begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        retry_count_next = retry_count_reg;
        tick_count_next  = tick_count_reg;
        res              = '0;
        res.event_res    = EV_NONE;
        if (step) begin
            case (item.cmd)
                CMD_START: begin
                    phase_next       = PH_WAIT;
                    retry_count_next = '0;
                    byte_count_next  = '0;
                    running_sum_next = '0;
                    tick_count_next  = '0;
                end
                CMD_TICK: begin
                    if (active) begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= frame_timeout_reg) begin
                            byte_count_next  = '0;
                            running_sum_next = '0;
                            tick_count_next  = '0;
                            if (phase_reg == PH_WAIT) begin
                                retry_count_next = retry_inc;
                                if (retry_inc >= request_limit_reg) begin
                                    phase_next    = PH_IDLE;
                                    res.event_res = EV_FAIL;
                                end else begin
                                    res.event_res = EV_REQ;
                                    res.tx_valid  = 1'b1;
                                    res.tx_byte   = CODE_NAK;
                                end
                            end else begin
                                // drop the partial frame
                                res.event_res = EV_NAK;
                                res.tx_valid  = 1'b1;
                                res.tx_byte   = CODE_NAK;
                            end
                        end
                    end
                end
                CMD_BYTE: begin
                    if (active) begin
                        phase_next = PH_RECV;
                        if (byte_count_reg == '0 && item.rx_byte == CODE_EOT) begin
                            phase_next       = PH_IDLE;
                            byte_count_next  = '0;
                            running_sum_next = '0;
                            tick_count_next  = '0;
                            res.event_res    = EV_DONE;
                            res.tx_valid     = 1'b1;
                            res.tx_byte      = CODE_ACK;
                        end else if (byte_count_reg >= SUM_POS) begin
                            byte_count_next  = '0;
                            running_sum_next = '0;
                            tick_count_next  = '0;
                            res.tx_valid     = 1'b1;
                            if (running_sum_reg == item.rx_byte) begin
                                res.event_res = EV_ACK;
                                res.tx_byte   = CODE_ACK;
                            end else begin
                                res.event_res = EV_NAK;
                                res.tx_byte   = CODE_NAK;
                            end
                        end else begin
                            if (byte_count_reg >= DATA_FIRST) begin
                                running_sum_next = running_sum_reg + item.rx_byte;
                                res.event_res    = EV_DATA;
                                res.data_valid   = 1'b1;
                                res.data_byte    = item.rx_byte;
                                res.data_index   = data_offset[INDEX_W-1:0];
                            end
                            byte_count_next = byte_count_reg + 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            retry_count_reg <= '0;
            tick_count_reg  <= '0;
        end else begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            retry_count_reg <= retry_count_next;
            tick_count_reg  <= tick_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_timeout_reg <= TIMEOUT_RESET;
            request_limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_wr_index))
                REG_FRAME_TIMEOUT: frame_timeout_reg <= cfg_wr_data;
                REG_REQUEST_LIMIT: request_limit_reg <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* hdl/xcr_output_reg.sv */
// Result register of the receiver pipeline.
`default_nettype none
module xcr_output_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  wire xcr_pkg::res_t res,
    output logic               can_load,
    output logic               out_valid,
    input  wire logic          out_ready,
    output xcr_pkg::res_t      out_res
);
    import xcr_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire

/* hdl/xmodem_checksum_receiver_unit.sv */
// Top level of the XMODEM checksum receiver.
//
// Receiver side of XMODEM with the 8-bit checksum and 128-byte frames. Each
// input transaction is a received byte, a time tick or a start command; each
// gives exactly one result transaction with an event code, an optional reply
// byte (ACK or NAK) and an optional tentative payload byte with its offset.
// The block takes one transaction per cycle unless the result side stalls;
// a result passes the input register, then the result register, and the
// whole per-item state update (checksum add, counter step, timeout compare)
// is combinational between them. Configuration writes go to frame_timeout
// (index 0) and request_limit (index 1); the user must write only while no
// transaction is in flight, the block itself does not enforce it.
`default_nettype none
module xmodem_checksum_receiver_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_index,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] tx_byte, [15:8] data_byte, [22:16] data_index
    output logic [4:0]       m_tuser    // [2:0] event_res, [3] tx_valid, [4] data_valid
);
    import xcr_pkg::*;

    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  can_load;
    logic  advance;
    res_t  res;
    res_t  out_res;

    assign in_item.cmd     = cmd_t'(s_tuser);
    assign in_item.rx_byte = s_tdata;
    assign advance         = item_valid && can_load;

    xcr_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    xcr_frame_fsm u_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .step         (advance),
        .item         (item),
        .res          (res)
    );

    xcr_output_reg u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .res       (res),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {1'b0, out_res.data_index, out_res.data_byte, out_res.tx_byte};
    assign m_tuser = {out_res.data_valid, out_res.tx_valid, out_res.event_res};

    // input side stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_tx_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3]) |-> (m_tdata[7:0] == CODE_ACK || m_tdata[7:0] == CODE_NAK))
        else $error("reply byte is neither ACK nor NAK");

    a_data_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[4] == (m_tuser[2:0] == EV_DATA)))
        else $error("payload flag disagrees with event code");

    a_accept_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !m_tvalid) |=> ##1 m_tvalid)
        else $error("accepted transaction produced no result");

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Testbench of the XMODEM checksum receiver: directed and random streams checked by a predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xcr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [7:0] CODE_SOH   = 8'h01;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_index;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [4:0]  m_tuser;

    xmodem_checksum_receiver_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    // receiver model state and its copy of the registers
    phase_t      rx_phase    = PH_IDLE;
    logic [7:0]  frame_pos   = '0;
    logic [7:0]  frame_sum   = '0;
    logic [7:0]  retries     = '0;
    logic [15:0] ticks       = '0;
    logic [15:0] timeout_reg = TIMEOUT_RESET;
    logic [7:0]  limit_reg   = LIMIT_RESET;

    res_t expected_replies[$];
    int   error_count = 0;
    int   items_sent  = 0;
    int   s_gap_max   = 14;
    int   m_gap_max   = 14;
    int   tick_odds   = 0;
    logic [7:0] block_num = 8'h01;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("xmodem_checksum_receiver_unit regression: fail");
        $finish;
    end

    function automatic void restart_frame();
        frame_pos = '0;
        frame_sum = '0;
        ticks     = '0;
    endfunction

    function automatic res_t predict_reply(logic [1:0] cmd, logic [7:0] b);
        res_t r;
        logic active;
        r = '0;
        r.event_res = EV_NONE;
        active = (rx_phase == PH_WAIT) || (rx_phase == PH_RECV);
        if (cmd == CMD_START) begin
            rx_phase = PH_WAIT;
            retries  = '0;
            restart_frame();
            return r;
        end
        if (cmd == CMD_UNUSED || !active)
            return r;
        if (cmd == CMD_TICK) begin
            if (ticks != 16'hFFFF)
                ticks++;
            if (ticks < timeout_reg)
                return r;
            restart_frame();
            if (rx_phase == PH_WAIT) begin
                if (retries != 8'hFF)
                    retries++;
                if (retries >= limit_reg) begin
                    rx_phase = PH_IDLE;
                    r.event_res = EV_FAIL;
                end else begin
                    r.event_res = EV_REQ;
                    r.tx_valid  = 1'b1;
                    r.tx_byte   = CODE_NAK;
                end
            end else begin
                r.event_res = EV_NAK;
                r.tx_valid  = 1'b1;
                r.tx_byte   = CODE_NAK;
            end
            return r;
        end
        rx_phase = PH_RECV;
        if (frame_pos == 8'd0 && b == CODE_EOT) begin
            rx_phase = PH_IDLE;
            restart_frame();
            r.event_res = EV_DONE;
            r.tx_valid  = 1'b1;
            r.tx_byte   = CODE_ACK;
            return r;
        end
        if (frame_pos >= SUM_POS) begin
            r.event_res = (frame_sum == b) ? EV_ACK : EV_NAK;
            r.tx_valid  = 1'b1;
            r.tx_byte   = (frame_sum == b) ? CODE_ACK : CODE_NAK;
            restart_frame();
            return r;
        end
        if (int'(frame_pos) >= HEAD_BYTES && int'(frame_pos) < HEAD_BYTES + DATA_BYTES) begin
            r.event_res  = EV_DATA;
            r.data_valid = 1'b1;
            r.data_byte  = b;
            r.data_index = INDEX_W'(frame_pos - DATA_FIRST);
            frame_sum    = frame_sum + b;
        end
        frame_pos++;
        return r;
    endfunction

    task automatic send_item(logic [1:0] cmd, logic [7:0] b);
        int gap;
        gap = $urandom_range(0, s_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_replies.push_back(predict_reply(cmd, b));
        items_sent++;
    endtask

    // hold the input side until every reply is back, then let the pipeline settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        wait_drain();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_TIMEOUT)
            timeout_reg = val;
        else
            limit_reg = val[7:0];
    endtask

    // fill < 0 draws random payload; a bad frame gets a wrong sum byte
    task automatic send_frame(int fill, bit good);
        logic [7:0] sum;
        logic [7:0] d;
        sum = '0;
        send_item(CMD_BYTE, CODE_SOH);
        send_item(CMD_BYTE, block_num);
        send_item(CMD_BYTE, ~block_num);
        for (int k = 0; k < DATA_BYTES; k++) begin
            d = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum = sum + d;
            send_item(CMD_BYTE, d);
            if (tick_odds != 0 && $urandom_range(0, tick_odds - 1) == 0)
                send_item(CMD_TICK, 8'($urandom));
        end
        send_item(CMD_BYTE, good ? sum : sum + 8'($urandom_range(1, 255)));
        block_num++;
    endtask

    task automatic test_directed_cases();
        // idle ignores everything
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_UNUSED, 8'hA5);
        // EOT as first byte ends the transfer
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, CODE_EOT);
        send_item(CMD_BYTE, 8'h5A);
        // restart, then EOT past the first byte is only a header byte
        send_item(CMD_START, 8'hFF);
        send_item(CMD_START, 8'h00);
        send_item(CMD_UNUSED, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, CODE_EOT);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_START, 8'h00);
        write_reg(REG_FRAME_TIMEOUT, 16'd1);
        write_reg(REG_REQUEST_LIMIT, 16'd3);
        // request retries, then give up
        send_item(CMD_START, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'h00);
        // timeout in mid-transfer drops the partial frame
        send_item(CMD_START, 8'h00);
        send_item(CMD_BYTE, CODE_SOH);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_BYTE, CODE_EOT);
    endtask

    task automatic test_full_frames();
        write_reg(REG_FRAME_TIMEOUT, TIMEOUT_RESET);
        write_reg(REG_REQUEST_LIMIT, LIMIT_RESET);
        send_item(CMD_START, 8'h00);
        send_frame(8'hFF, 1'b1);
        // ticks between payload bytes stay below the timeout
        tick_odds = 16;
        send_frame(-1, 1'b0);
        tick_odds = 0;
        send_item(CMD_BYTE, CODE_EOT);
    endtask

    task automatic test_request_limit();
        write_reg(REG_FRAME_TIMEOUT, 16'd1);
        write_reg(REG_REQUEST_LIMIT, 16'd6);
        send_item(CMD_START, 8'h00);
        repeat (7) send_item(CMD_TICK, 8'($urandom));
        write_reg(REG_REQUEST_LIMIT, 16'd1);
        send_item(CMD_START, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_TICK, 8'h00);
    endtask

    task automatic test_timeout_boundary();
        write_reg(REG_FRAME_TIMEOUT, 16'd5);
        write_reg(REG_REQUEST_LIMIT, 16'd2);
        s_gap_max = 0;
        m_gap_max = 0;
        send_item(CMD_START, 8'h00);
        repeat (5) send_item(CMD_TICK, 8'h00);
        send_item(CMD_BYTE, CODE_SOH);
        repeat (5) send_item(CMD_TICK, 8'h00);
        send_item(CMD_BYTE, CODE_EOT);
        wait_drain();
        s_gap_max = 14;
        m_gap_max = 14;
    endtask

    task automatic test_random_traffic();
        int mark;
        int kind;
        int cut;
        for (int setting = 0; setting < 4; setting++) begin
            case (setting)
                0: begin
                    write_reg(REG_FRAME_TIMEOUT, 16'($urandom_range(2, 12)));
                    write_reg(REG_REQUEST_LIMIT, 16'($urandom_range(2, 6)));
                end
                1: begin
                    write_reg(REG_FRAME_TIMEOUT, 16'd1);
                    write_reg(REG_REQUEST_LIMIT, 16'd1);
                end
                2: begin
                    write_reg(REG_FRAME_TIMEOUT, 16'hFFFF);
                    write_reg(REG_REQUEST_LIMIT, 16'd255);
                end
                default: begin
                    write_reg(REG_FRAME_TIMEOUT, 16'($urandom_range(300, 3000)));
                    write_reg(REG_REQUEST_LIMIT, 16'($urandom_range(1, 255)));
                end
            endcase
            mark = items_sent;
            while (items_sent - mark < 20) begin
                if ($urandom_range(0, 3) == 0) begin
                    s_gap_max = 0;
                    m_gap_max = 0;
                end else begin
                    s_gap_max = 14;
                    m_gap_max = 14;
                end
                kind = $urandom_range(0, 5);
                if (kind == 0) begin
                    repeat ($urandom_range(1, 8))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom));
                end else if (kind == 1) begin
                    send_item(CMD_START, 8'($urandom));
                    repeat ($urandom_range(1, 5)) send_item(CMD_TICK, 8'($urandom));
                end else if (kind <= 3) begin
                    // truncated frame: leave it to a timeout or a restart
                    if ($urandom_range(0, 3) != 0)
                        send_item(CMD_START, 8'($urandom));
                    cut = $urandom_range(1, 12);
                    for (int k = 0; k < cut; k++) send_item(CMD_BYTE, 8'($urandom));
                    if (timeout_reg <= 16'd12)
                        repeat (int'(timeout_reg)) send_item(CMD_TICK, 8'($urandom));
                    else
                        send_item(CMD_START, 8'($urandom));
                end else if (kind == 4) begin
                    send_item(CMD_START, 8'($urandom));
                    send_item(CMD_BYTE, CODE_EOT);
                end else begin
                    send_item(CMD_START, 8'($urandom));
                    send_item(CMD_BYTE, CODE_SOH);
                    send_item(CMD_BYTE, CODE_EOT);
                    send_item(CMD_TICK, 8'($urandom));
                end
                if ($urandom_range(0, 3) == 0)
                    wait_drain();
            end
        end
        s_gap_max = 14;
        m_gap_max = 14;
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    // result side: random stalls, compare each transaction with the oldest prediction
    initial begin
        int   gap;
        res_t want;
        forever begin
            gap = $urandom_range(0, m_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (expected_replies.size() == 0) begin
                $error("result transaction with no prediction pending: tdata %0h tuser %0h",
                       m_tdata, m_tuser);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                check_field("event_res", 8'(want.event_res), 8'(m_tuser[2:0]));
                check_field("tx_valid", 8'(want.tx_valid), 8'(m_tuser[3]));
                check_field("tx_byte", want.tx_byte, m_tdata[7:0]);
                check_field("data_valid", 8'(want.data_valid), 8'(m_tuser[4]));
                check_field("data_byte", want.data_byte, m_tdata[15:8]);
                check_field("data_index", 8'(want.data_index), 8'(m_tdata[22:16]));
            end
        end
    end

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= 1'b0;
        cfg_wr_data  <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_full_frames();
        test_request_limit();
        test_timeout_boundary();
        test_random_traffic();
        wait_drain();
        repeat (10) @(posedge aclk);
        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("xmodem_checksum_receiver_unit regression: pass");
        end else begin
            $display("xmodem_checksum_receiver_unit regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
